// ----- src/nmea_sentence_framer_checker_defines.svh -----
// assertion macros for the nmea sentence framer checker
// expects clk and arst_n in the scope of each use
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH

// same-cycle implication, off while in reset
`define NSFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define NSFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/nsfc_pkg.sv -----
// shared types, constants and lookup functions of the nmea sentence framer checker
// no dependencies
package nsfc_pkg;

	localparam int LINE_BUFFER_BYTES_DEF = 128;
	localparam int ADDR_MAX = 7;
	localparam int NUM_TPL = 15;
	localparam logic [3:0] NO_TYPE = 4'd15;
	localparam int QUEUE_DEPTH = 2;
	localparam int QAW = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_LOW = 8'd32;
	localparam logic [7:0] CH_HIGH = 8'd127;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_DIG_HI,
		PH_DIG_LO,
		PH_CR,
		PH_TAIL
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_CHAR,
		ST_BAD_SUM,
		ST_NO_CR
	} status_t;

	typedef struct packed {
		status_t err;
		logic [ADDR_MAX-1:0][7:0] addr;
		logic [3:0] alen;
		logic [7:0] commas;
		logic [7:0] xsum;
	} line_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// templates padded with wildcards to the full address width
	localparam logic [ADDR_MAX*8-1:0] TPL_TEXT [NUM_TPL] = '{
		"**GGA**", "**RMC**", "POHPR**", "POUGT**", "PODST**",
		"PONDM**", "PORZA**", "PORZB**", "PONGL**", "PNVGO**",
		"PNVGVER", "PNVGS**", "PNVGR**", "PORZV**", "**ZDA**"
	};

	localparam logic [3:0] TPL_LEN [NUM_TPL] = '{
		4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
		4'd5, 4'd5, 4'd7, 4'd5, 4'd5, 4'd5, 4'd5
	};

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'h0, n};
		end else begin
			r = 8'h37 + {4'h0, n};
		end
		return r;
	endfunction

	function automatic logic [3:0] tpl_match(input logic [ADDR_MAX-1:0][7:0] chars,
			input logic [3:0] alen);
		logic [3:0] idx;
		logic hit;
		logic [7:0] tc;
		idx = NO_TYPE;
		for (int i = NUM_TPL - 1; i >= 0; i--) begin
			hit = (TPL_LEN[i] == alen);
			for (int j = 0; j < ADDR_MAX; j++) begin
				tc = TPL_TEXT[i][8*(ADDR_MAX-1-j) +: 8];
				if (tc != CH_STAR && tc != chars[j]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- src/nmea_sentence_framer_checker.sv -----
// top level of the nmea sentence framer checker: front, queue and back
// depends on nsfc_pkg, nsfc_front, nsfc_queue, nsfc_back and the defines header
//
// usage:
// - input stream s_*: one received character per word, tdata[7:0]
// - output stream m_*: one word per lf that ends a captured line
// - a '$' starts a line; over-long lines and bytes outside a line give no word
// - throughput: one input word per cycle while the queue is not full, including across lf
// - the lf word is written into the queue at its accepting edge, and the back part pops it
//   into the output register once that register is empty or being taken
// - the front stalls (s_tready low) only when the two-entry queue is full,
//   which needs three results held up by m_tready low (two queued, one in the output register)
// - results wait in the queue and the output register while m_tready is low;
//   none are dropped
// - reset: asynchronous, clears phase, counters, queue and output valid;
//   the block is idle and drops bytes until the first '$'
`include "nmea_sentence_framer_checker_defines.svh"

module nmea_sentence_framer_checker import nsfc_pkg::*; #(
	parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status[1:0], sentence_type[5:2], comma_count[13:6],
	                               // xor_sum[21:14], zero[23:22]
);

	logic q_push, q_pop, in_fire;
	line_t push_line, head_line;
	q_stat_t q_stat;

	assign s_tready = !q_stat.full;
	assign in_fire = s_tvalid && s_tready;

	nsfc_front #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (in_fire),
		.rx_byte (s_tdata),
		.push    (q_push),
		.line    (push_line)
	);

	nsfc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_line (push_line),
		.pop     (q_pop),
		.rd_line (head_line),
		.stat    (q_stat)
	);

	nsfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.line      (head_line),
		.stat      (q_stat),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	`NSFC_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "queue write while full")
	`NSFC_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty, "queue read while empty")
	`NSFC_ASSERT_NOW(a_type_on_error, m_tvalid && m_tdata[1:0] != ST_OK,
		m_tdata[5:2] == NO_TYPE, "template index on a failed line")
	`NSFC_ASSERT_NEXT(a_pop_loads_out, q_pop, m_tvalid, "popped line not presented")

endmodule

// ----- src/nsfc_front.sv -----
// front part: framing state machine, xor, comma count and address capture per byte
// depends on nsfc_pkg
module nsfc_front import nsfc_pkg::*; #(
	parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	output logic       push,
	output line_t      line
);

	localparam int POS_W = $clog2(LINE_BUFFER_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_BUFFER_BYTES);
	localparam logic [7:0] COMMA_SAT = 8'((LINE_BUFFER_BYTES > 255) ? 255 : LINE_BUFFER_BYTES);

	phase_t phase_q, phase_d;
	logic [POS_W-1:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] commas_q;
	logic [ADDR_MAX-1:0][7:0] chars_q;
	logic [3:0] alen_q;
	logic closed_q;
	status_t err_q;

	logic is_dollar, live, is_lf, body_live, char_ok, char_wr;
	status_t err_fin;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			if (rx_byte == CH_DOLLAR) begin
				phase_d = PH_BODY;
			end else if (phase_q != PH_IDLE) begin
				if (pos_q >= POS_MAX || rx_byte == CH_LF) begin
					phase_d = PH_IDLE;
				end else begin
					case (phase_q)
						PH_BODY:   if (rx_byte == CH_STAR) phase_d = PH_DIG_HI;
						PH_DIG_HI: phase_d = PH_DIG_LO;
						PH_DIG_LO: phase_d = PH_CR;
						PH_CR:     phase_d = PH_TAIL;
						default:   phase_d = phase_q;
					endcase
				end
			end
		end
	end

	// per-byte decisions
	always_comb begin
		is_dollar = (rx_byte == CH_DOLLAR);
		is_lf = (rx_byte == CH_LF);
		live = fire && !is_dollar && phase_q != PH_IDLE && pos_q < POS_MAX;
		push = live && is_lf;
		char_ok = rx_byte inside {[CH_LOW:CH_HIGH]};
		body_live = live && !is_lf && phase_q == PH_BODY && rx_byte != CH_STAR &&
			err_q == ST_OK;
		char_wr = body_live && char_ok && rx_byte != CH_COMMA && !closed_q &&
			alen_q < 4'(ADDR_MAX);
		err_fin = err_q;
		if (err_q == ST_OK) begin
			case (phase_q)
				PH_BODY:   err_fin = ST_BAD_CHAR;
				PH_DIG_HI: err_fin = ST_BAD_SUM;
				PH_DIG_LO: err_fin = ST_BAD_SUM;
				PH_CR:     err_fin = ST_NO_CR;
				default:   err_fin = err_q;
			endcase
		end
		line.err = err_fin;
		line.addr = chars_q;
		line.alen = alen_q;
		line.commas = commas_q;
		line.xsum = xor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			xor_q <= '0;
			commas_q <= '0;
			alen_q <= '0;
			closed_q <= 1'b0;
			err_q <= ST_OK;
		end else begin
			phase_q <= phase_d;
			if (fire && is_dollar) begin
				pos_q <= POS_W'(1);
				xor_q <= '0;
				commas_q <= '0;
				alen_q <= '0;
				closed_q <= 1'b0;
				err_q <= ST_OK;
			end else if (live) begin
				pos_q <= pos_q + 1'b1;
				if (!is_lf) begin
					case (phase_q)
						PH_BODY: begin
							if (rx_byte == CH_STAR) begin
								closed_q <= 1'b1;
							end else if (body_live) begin
								if (!char_ok) begin
									err_q <= ST_BAD_CHAR;
								end else begin
									xor_q <= xor_q ^ rx_byte;
									if (rx_byte == CH_COMMA) begin
										if (commas_q < COMMA_SAT) commas_q <= commas_q + 1'b1;
										closed_q <= 1'b1;
									end else if (!closed_q && alen_q <= 4'(ADDR_MAX)) begin
										alen_q <= alen_q + 1'b1;
									end
								end
							end
						end
						PH_DIG_HI: begin
							if (rx_byte != hex_char(xor_q[7:4]) && err_q == ST_OK)
								err_q <= ST_BAD_SUM;
						end
						PH_DIG_LO: begin
							if (rx_byte != hex_char(xor_q[3:0]) && err_q == ST_OK)
								err_q <= ST_BAD_SUM;
						end
						PH_CR: begin
							if (rx_byte != CH_CR && err_q == ST_OK) err_q <= ST_NO_CR;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_wr) begin
			chars_q[alen_q[2:0]] <= rx_byte;
		end
	end

endmodule

// ----- src/nsfc_queue.sv -----
// short queue of finished line summaries between front and back
// depends on nsfc_pkg
module nsfc_queue import nsfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  line_t   wr_line,
	input  logic    pop,
	output line_t   rd_line,
	output q_stat_t stat
);

	line_t entries_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0] count_q;

	always_comb begin
		stat.full = (count_q == (QAW+1)'(QUEUE_DEPTH));
		stat.empty = (count_q == '0);
		rd_line = entries_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_line;
		end
	end

endmodule

// ----- src/nsfc_back.sv -----
// back part: template lookup and the registered result word
// depends on nsfc_pkg
module nsfc_back import nsfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  line_t       line,
	input  q_stat_t     stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] out_data
);

	logic out_valid_q;
	status_t status_q;
	logic [3:0] type_q;
	logic [7:0] commas_q;
	logic [7:0] xsum_q;

	assign pop = !stat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = {2'b00, xsum_q, commas_q, type_q, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= line.err;
			type_q <= (line.err == ST_OK) ? tpl_match(line.addr, line.alen) : NO_TYPE;
			commas_q <= line.commas;
			xsum_q <= line.xsum;
		end
	end

endmodule

// ----- verif/nsfc_result_monitor.sv -----
// result monitor for the nmea sentence framer checker: predicts one result per captured line
// and compares every output word with the oldest prediction; depends on nsfc_pkg
module nsfc_result_monitor import nsfc_pkg::*; #(
	parameter int LINE_BYTES = LINE_BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          fail_count,
	output int          waiting
);

	localparam int COMMA_CAP = (LINE_BYTES > 255) ? 255 : LINE_BYTES;

	// address templates, right aligned, '*' matches any character
	localparam logic [55:0] ADDR_TPL [NUM_TPL] = '{
		"**GGA", "**RMC", "POHPR", "POUGT", "PODST",
		"PONDM", "PORZA", "PORZB", "PONGL", "PNVGO",
		"PNVGVER", "PNVGS", "PNVGR", "PORZV", "**ZDA"
	};
	localparam int ADDR_TPL_LEN [NUM_TPL] = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 7, 5, 5, 5, 5};

	typedef struct {
		status_t    st;
		logic [3:0] stype;
		logic [7:0] commas;
		logic [7:0] xsum;
	} line_result_t;

	line_result_t expected_lines[$];

	phase_t     fr_phase;
	int         fr_pos;
	logic [7:0] fr_xor;
	int         fr_commas;
	logic [7:0] fr_addr [ADDR_MAX];
	int         fr_alen;
	bit         fr_closed;
	status_t    fr_err;

	initial begin
		fail_count = 0;
		waiting = 0;
		fr_phase = PH_IDLE;
		fr_pos = 0;
		fr_xor = 8'h00;
		fr_commas = 0;
		fr_alen = 0;
		fr_closed = 1'b0;
		fr_err = ST_OK;
	end

	function automatic logic [7:0] sum_digit(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
	endfunction

	function automatic logic [3:0] sentence_index();
		logic hit;
		logic [7:0] tc;
		for (int i = 0; i < NUM_TPL; i++) begin
			if (ADDR_TPL_LEN[i] == fr_alen) begin
				hit = 1'b1;
				for (int j = 0; j < fr_alen; j++) begin
					tc = ADDR_TPL[i][8*(ADDR_TPL_LEN[i]-1-j) +: 8];
					if (tc != CH_STAR && tc != fr_addr[j]) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					return 4'(i);
				end
			end
		end
		return NO_TYPE;
	endfunction

	task automatic flag_error(input status_t code);
		if (fr_err == ST_OK) begin
			fr_err = code;
		end
	endtask

	task automatic advance_line(input logic [7:0] b);
		line_result_t r;
		if (b == CH_DOLLAR) begin
			fr_phase = PH_BODY;
			fr_pos = 1;
			fr_xor = 8'h00;
			fr_commas = 0;
			fr_alen = 0;
			fr_closed = 1'b0;
			fr_err = ST_OK;
		end else if (fr_phase == PH_IDLE) begin
		end else if (fr_pos >= LINE_BYTES) begin
			fr_phase = PH_IDLE;
		end else begin
			fr_pos++;
			if (b == CH_LF) begin
				case (fr_phase)
					PH_BODY: flag_error(ST_BAD_CHAR);
					PH_DIG_HI, PH_DIG_LO: flag_error(ST_BAD_SUM);
					PH_CR: flag_error(ST_NO_CR);
					default: ;
				endcase
				r.st = fr_err;
				r.stype = (fr_err == ST_OK) ? sentence_index() : NO_TYPE;
				r.commas = 8'(fr_commas);
				r.xsum = fr_xor;
				expected_lines.push_back(r);
				fr_phase = PH_IDLE;
			end else begin
				case (fr_phase)
					PH_BODY: begin
						if (b == CH_STAR) begin
							fr_closed = 1'b1;
							fr_phase = PH_DIG_HI;
						end else if (fr_err == ST_OK) begin
							if (b < CH_LOW || b > CH_HIGH) begin
								fr_err = ST_BAD_CHAR;
							end else begin
								fr_xor ^= b;
								if (b == CH_COMMA) begin
									if (fr_commas < COMMA_CAP) begin
										fr_commas++;
									end
									fr_closed = 1'b1;
								end else if (!fr_closed) begin
									if (fr_alen < ADDR_MAX) begin
										fr_addr[fr_alen] = b;
									end
									if (fr_alen <= ADDR_MAX) begin
										fr_alen++;
									end
								end
							end
						end
					end
					PH_DIG_HI: begin
						if (b != sum_digit(fr_xor[7:4])) begin
							flag_error(ST_BAD_SUM);
						end
						fr_phase = PH_DIG_LO;
					end
					PH_DIG_LO: begin
						if (b != sum_digit(fr_xor[3:0])) begin
							flag_error(ST_BAD_SUM);
						end
						fr_phase = PH_CR;
					end
					PH_CR: begin
						if (b != CH_CR) begin
							flag_error(ST_NO_CR);
						end
						fr_phase = PH_TAIL;
					end
					default: ;
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		line_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_line(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (expected_lines.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result word %h", m_tdata);
					end
				end else begin
					want = expected_lines.pop_front();
					if (m_tdata[1:0] != want.st || m_tdata[5:2] != want.stype ||
							m_tdata[13:6] != want.commas || m_tdata[21:14] != want.xsum) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result mismatch: expected status %0d type %0d commas %0d xor %h, got status %0d type %0d commas %0d xor %h",
								want.st, want.stype, want.commas, want.xsum,
								m_tdata[1:0], m_tdata[5:2], m_tdata[13:6], m_tdata[21:14]);
						end
					end
				end
			end
			waiting = expected_lines.size();
		end
	end

endmodule

// ----- verif/tb_nmea_sentence_framer_checker.sv -----
// testbench top for the nmea sentence framer checker: clock, reset, byte stimulus and verdict
// depends on nsfc_pkg, the block and nsfc_result_monitor
module tb_nmea_sentence_framer_checker;
	import nsfc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1550;

	typedef enum int {
		FT_GOOD,
		FT_BAD_HI,
		FT_BAD_LO,
		FT_NO_CR,
		FT_EARLY_LF,
		FT_LF_AT_HI,
		FT_LF_AT_LO,
		FT_LF_AT_CR,
		FT_TAIL_JUNK
	} line_fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;
	int          fail_count;
	int          waiting;
	bit          calm = 1'b0;
	int          cycles = 0;
	int          line_bytes = 0;
	logic [7:0]  body_q[$];

	string addr_seeds [NUM_TPL] = '{
		"**GGA", "**RMC", "POHPR", "POUGT", "PODST",
		"PONDM", "PORZA", "PORZB", "PONGL", "PNVGO",
		"PNVGVER", "PNVGS", "PNVGR", "PORZV", "**ZDA"
	};

	nmea_sentence_framer_checker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	nsfc_result_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** nmea_sentence_framer_checker: FAILED **");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 31);
	end

	task automatic send_byte(input logic [7:0] b);
		if (!calm) begin
			while ($urandom_range(0, 99) < 31) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic put_byte(input logic [7:0] b);
		line_bytes++;
		send_byte(b);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (waiting != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [7:0] rand_printable();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(32, 127));
		end while (b == CH_DOLLAR || b == CH_STAR);
		return b;
	endfunction

	function automatic logic [7:0] rand_bad();
		logic [7:0] b;
		b = $urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 31));
		return (b == CH_LF) ? 8'h00 : b;
	endfunction

	function automatic logic [7:0] rand_junk();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CH_DOLLAR || b == CH_LF || b == CH_CR);
		return b;
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			body_q.push_back(s[i]);
		end
	endtask

	task automatic add_fields(input int n, input int maxlen);
		int k;
		for (int i = 0; i < n; i++) begin
			body_q.push_back(CH_COMMA);
			k = $urandom_range(0, maxlen);
			for (int j = 0; j < k; j++) begin
				body_q.push_back(rand_printable());
			end
		end
	endtask

	// sends '$', the body, then star, digits, cr and lf shaped by the fault
	task automatic emit_line(input line_fault_t f);
		logic [7:0] x;
		logic [7:0] hi;
		logic [7:0] lo;
		x = 8'h00;
		foreach (body_q[i]) begin
			x ^= body_q[i];
		end
		hi = hex_ascii(x[7:4]);
		lo = hex_ascii(x[3:0]);
		if (f == FT_BAD_HI) begin
			hi = (hi >= 8'h41 && $urandom_range(0, 1)) ? hi | 8'h20 : hi ^ 8'h01;
		end
		if (f == FT_BAD_LO) begin
			lo = (lo >= 8'h41 && $urandom_range(0, 1)) ? lo | 8'h20 : lo ^ 8'h01;
		end
		put_byte(CH_DOLLAR);
		foreach (body_q[i]) begin
			put_byte(body_q[i]);
		end
		body_q.delete();
		if (f == FT_EARLY_LF) begin
			put_byte(CH_LF);
			return;
		end
		put_byte(CH_STAR);
		if (f == FT_LF_AT_HI) begin
			put_byte(CH_LF);
			return;
		end
		put_byte(hi);
		if (f == FT_LF_AT_LO) begin
			put_byte(CH_LF);
			return;
		end
		put_byte(lo);
		if (f == FT_LF_AT_CR) begin
			put_byte(CH_LF);
			return;
		end
		put_byte((f == FT_NO_CR) ? rand_junk() : CH_CR);
		if (f == FT_TAIL_JUNK) begin
			repeat ($urandom_range(1, 3)) put_byte(rand_junk());
		end
		put_byte(CH_LF);
	endtask

	task automatic add_address();
		int r;
		int k;
		string s;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			s = addr_seeds[$urandom_range(0, NUM_TPL - 1)];
			for (int i = 0; i < s.len(); i++) begin
				body_q.push_back((s[i] == CH_STAR) ? 8'h41 + 8'($urandom_range(0, 25)) : s[i]);
			end
			if ($urandom_range(0, 9) == 0) begin
				body_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
			end
		end else if (r < 80) begin
			k = $urandom_range(0, 9);
			repeat (k) body_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
		end else begin
			k = $urandom_range(0, 6);
			repeat (k) body_q.push_back(rand_printable());
		end
	endtask

	initial begin
		int n_lines;
		line_fault_t f;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bytes outside any line
		send_byte(CH_LF);
		send_byte(8'hFF);
		send_byte(8'h00);

		add_text("GPGGA,123519,4807.038,N");
		emit_line(FT_GOOD);
		add_text("PNVGVER,1.0");
		emit_line(FT_GOOD);
		add_text("PNVGVERX,1");
		emit_line(FT_GOOD);
		add_text(",,,");
		emit_line(FT_GOOD);
		add_text("GPZDA");
		emit_line(FT_GOOD);
		add_text("GPRMC,");
		body_q.push_back(CH_LOW);
		body_q.push_back(CH_HIGH);
		add_text(",A");
		emit_line(FT_GOOD);
		add_text("GPGGA,1");
		body_q.push_back(8'h00);
		add_text(",2");
		emit_line(FT_GOOD);
		add_text("GPGGA,");
		body_q.push_back(8'hFF);
		emit_line(FT_BAD_HI);
		add_text("GPGGA,");
		body_q.push_back(8'h1F);
		emit_line(FT_NO_CR);
		add_text("PORZA,1");
		emit_line(FT_BAD_HI);
		add_text("PORZB,2");
		emit_line(FT_BAD_LO);
		add_text("PONGL,3");
		emit_line(FT_NO_CR);
		add_text("PNVGS,4");
		emit_line(FT_EARLY_LF);
		add_text("PNVGR,5");
		emit_line(FT_LF_AT_HI);
		add_text("PORZV,6");
		emit_line(FT_LF_AT_LO);
		add_text("PODST,7");
		emit_line(FT_LF_AT_CR);
		add_text("PONDM,8");
		emit_line(FT_TAIL_JUNK);

		// restart inside a line
		put_byte(CH_DOLLAR);
		add_text("GPGGA,12");
		foreach (body_q[i]) put_byte(body_q[i]);
		body_q.delete();
		add_text("POUGT,9");
		emit_line(FT_GOOD);

		// longest line that still fits, then one byte too long
		add_text("GPGGA,");
		repeat (116) body_q.push_back(rand_printable());
		emit_line(FT_GOOD);
		add_text("GPGGA,");
		repeat (117) body_q.push_back(rand_printable());
		emit_line(FT_GOOD);
		send_byte(8'h55);
		add_text("POHPR,0");
		emit_line(FT_GOOD);

		wait_drained();

		n_lines = 0;
		while (line_bytes < ITEM_TARGET) begin
			calm = (n_lines >= 12 && n_lines < 22);
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 4)) send_byte(rand_junk());
			end
			if ($urandom_range(0, 19) == 0) begin
				put_byte(CH_DOLLAR);
				repeat ($urandom_range(0, 8)) put_byte(rand_printable());
			end
			add_address();
			if ($urandom_range(0, 14) == 0) begin
				add_fields($urandom_range(20, 32), 6);
			end else begin
				add_fields($urandom_range(0, 8), 6);
			end
			if ($urandom_range(0, 9) == 0) begin
				body_q.insert($urandom_range(0, body_q.size()), rand_bad());
			end
			f = ($urandom_range(0, 99) < 65) ? FT_GOOD : line_fault_t'($urandom_range(1, 8));
			emit_line(f);
			n_lines++;
			if ($urandom_range(0, 24) == 0) begin
				wait_drained();
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && waiting == 0) begin
			$display("** nmea_sentence_framer_checker: PASSED **");
		end else begin
			$display("** nmea_sentence_framer_checker: FAILED **");
		end
		$finish;
	end

endmodule
